/* hw/rtl/fm_synth_timer_register_front_macros.svh */
// assertion macros used by the checker of the register front
`ifndef FM_SYNTH_TIMER_REGISTER_FRONT_MACROS_SVH
`define FM_SYNTH_TIMER_REGISTER_FRONT_MACROS_SVH

// same-cycle implication, held off during reset
`define FMST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fmst assertion failed");

// next-cycle implication, held off during reset
`define FMST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fmst assertion failed");

`endif

/* hw/rtl/fmst_pkg.sv */
`timescale 1ns / 1ps

package fmst_pkg;

	localparam int CLOCK_W = 48;
	localparam int TICK_W = 16;
	localparam int REG_W = 9;

	localparam logic [TICK_W-1:0] TIMER1_TICK_RESET = 16'd80;
	localparam logic [TICK_W-1:0] TIMER2_TICK_RESET = 16'd320;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_TIME = 2'd2;

	localparam logic [1:0] PORT_ADDR = 2'd0;
	localparam logic [1:0] PORT_ADDR_HI = 2'd1;
	localparam logic [1:0] PORT_DATA = 2'd2;

	localparam logic [REG_W-1:0] REG_TIMER1 = 9'h002;
	localparam logic [REG_W-1:0] REG_TIMER2 = 9'h003;
	localparam logic [REG_W-1:0] REG_TIMER_CTRL = 9'h004;
	localparam logic [REG_W-1:0] REG_NEW = 9'h105;

	localparam logic CFG_TIMER1_TICK = 1'b0;
	localparam logic CFG_TIMER2_TICK = 1'b1;

	localparam logic [7:0] READ_BANK_HI = 8'hFF;

	typedef struct packed {
		logic       wr_reload;
		logic       stop;
		logic       set_run;
		logic       run_value;
		logic [7:0] value;
	} timer_cmd_t;

endpackage

/* hw/rtl/fmst_timer.sv */
`timescale 1ns / 1ps

module fmst_timer
	import fmst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  timer_cmd_t         cmd,
	input  logic [CLOCK_W-1:0] time_now,
	input  logic [TICK_W-1:0]  tick,
	output logic               expired
);

	logic [7:0]         reload_q;
	logic               running_q;
	logic [CLOCK_W-1:0] deadline_q;

	logic [7:0]              reload_sel;
	logic [8:0]              counts;
	logic [TICK_W+8:0]       span;
	logic [CLOCK_W:0]        sum;
	logic [CLOCK_W-1:0]      deadline_new;

	// deadline = time_now + (0x100 - reload) * tick, saturating
	always_comb begin
		reload_sel = cmd.wr_reload ? cmd.value : reload_q;
		counts = 9'h100 - {1'b0, reload_sel};
		span = counts * tick;
		sum = {1'b0, time_now} + (CLOCK_W+1)'(span);
		deadline_new = sum[CLOCK_W] ? {CLOCK_W{1'b1}} : sum[CLOCK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= '0;
			running_q <= 1'b0;
			deadline_q <= '0;
		end else begin
			if (cmd.wr_reload) begin
				reload_q <= cmd.value;
				if (running_q) begin
					deadline_q <= deadline_new;
				end
			end
			if (cmd.stop) begin
				running_q <= 1'b0;
			end else if (cmd.set_run) begin
				running_q <= cmd.run_value;
				if (cmd.run_value) begin
					deadline_q <= deadline_new;
				end
			end
		end
	end

	assign expired = running_q && (time_now > deadline_q);

endmodule

/* hw/rtl/fm_synth_timer_register_front.sv */
`timescale 1ns / 1ps
// an accepted input beat gives its result beat in the next cycle, from the result beat register
// throughput: one item per cycle while the output is not stalled; each item passes input decode,
// the timer deadline multiply-add and the status compares combinationally
// reset: arst_n clears the address latch, clock, timers and mode bit, and
// loads the tick registers with 80 us and 320 us

module fm_synth_timer_register_front
	import fmst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [TICK_W-1:0] cfg_data,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [1:0]        port,
	input  logic [7:0]        data_byte,
	input  logic [15:0]       elapsed_us,

	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        read_data,
	output logic              forward_valid,
	output logic [REG_W-1:0]  forward_register,
	output logic [7:0]        forward_value,
	output logic              wide_mode
);

	logic [TICK_W-1:0]  tick1_q;
	logic [TICK_W-1:0]  tick2_q;
	logic [REG_W-1:0]   addr_q;
	logic [CLOCK_W-1:0] time_q;
	logic               mode_q;

	logic               out_valid_q;
	logic [7:0]         read_data_q;
	logic               fwd_valid_q;
	logic [REG_W-1:0]   fwd_reg_q;
	logic [7:0]         fwd_val_q;
	logic               wide_q;

	logic               accept;
	logic               exp1;
	logic               exp2;
	logic [7:0]         status;
	logic [CLOCK_W:0]   time_sum;

	logic [REG_W-1:0]   addr_d;
	logic [CLOCK_W-1:0] time_d;
	logic               mode_d;
	logic [7:0]         rd_d;
	logic               fwd_valid_d;
	logic [REG_W-1:0]   fwd_reg_d;
	logic [7:0]         fwd_val_d;
	timer_cmd_t         cmd1;
	timer_cmd_t         cmd2;

	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick1_q <= TIMER1_TICK_RESET;
			tick2_q <= TIMER2_TICK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMER1_TICK: tick1_q <= cfg_data;
				CFG_TIMER2_TICK: tick2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign status = {exp1 || exp2, exp1, exp2, 5'b0};
	assign time_sum = {1'b0, time_q} + (CLOCK_W+1)'(elapsed_us);

	always_comb begin
		addr_d = addr_q;
		time_d = time_q;
		mode_d = mode_q;
		rd_d = '0;
		fwd_valid_d = 1'b0;
		fwd_reg_d = '0;
		fwd_val_d = '0;
		cmd1 = '0;
		cmd2 = '0;
		cmd1.value = data_byte;
		cmd2.value = data_byte;
		unique case (kind)
			KIND_WRITE: begin
				unique case (port)
					PORT_ADDR: addr_d = {1'b0, data_byte};
					PORT_ADDR_HI: addr_d = {1'b1, data_byte};
					PORT_DATA: begin
						unique case (addr_q)
							REG_TIMER1: cmd1.wr_reload = 1'b1;
							REG_TIMER2: cmd2.wr_reload = 1'b1;
							REG_TIMER_CTRL: begin
								cmd1.stop = data_byte[7];
								cmd2.stop = data_byte[7];
								cmd1.set_run = !data_byte[7] && !data_byte[6];
								cmd2.set_run = !data_byte[7] && !data_byte[5];
								cmd1.run_value = data_byte[0];
								cmd2.run_value = data_byte[1];
							end
							default: begin
								fwd_valid_d = 1'b1;
								fwd_reg_d = addr_q;
								fwd_val_d = data_byte;
								if (addr_q == REG_NEW) begin
									mode_d = data_byte[0];
								end
							end
						endcase
					end
					default: ;
				endcase
			end
			KIND_READ: rd_d = (port == PORT_ADDR_HI) ? READ_BANK_HI : status;
			KIND_TIME: begin
				time_d = time_sum[CLOCK_W] ? {CLOCK_W{1'b1}} : time_sum[CLOCK_W-1:0];
			end
			default: ;
		endcase
		if (!accept) begin
			cmd1.wr_reload = 1'b0;
			cmd1.stop = 1'b0;
			cmd1.set_run = 1'b0;
			cmd2.wr_reload = 1'b0;
			cmd2.stop = 1'b0;
			cmd2.set_run = 1'b0;
		end
	end

	fmst_timer u_timer1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd1),
		.time_now (time_q),
		.tick     (tick1_q),
		.expired  (exp1)
	);

	fmst_timer u_timer2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd2),
		.time_now (time_q),
		.tick     (tick2_q),
		.expired  (exp2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			time_q <= '0;
			mode_q <= 1'b0;
		end else if (accept) begin
			addr_q <= addr_d;
			time_q <= time_d;
			mode_q <= mode_d;
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= rd_d;
			fwd_valid_q <= fwd_valid_d;
			fwd_reg_q <= fwd_reg_d;
			fwd_val_q <= fwd_val_d;
			wide_q <= mode_d;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign forward_valid = fwd_valid_q;
	assign forward_register = fwd_reg_q;
	assign forward_value = fwd_val_q;
	assign wide_mode = wide_q;

endmodule

/* hw/rtl/fmst_checker.sv */
`timescale 1ns / 1ps
`include "fm_synth_timer_register_front_macros.svh"

module fmst_checker
	import fmst_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [7:0]        read_data,
	input logic              forward_valid,
	input logic [REG_W-1:0]  forward_register,
	input logic [7:0]        forward_value,
	input logic              wide_mode
);

	// a stalled result beat holds
	`FMST_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(read_data) && $stable(forward_valid) && $stable(forward_register) && $stable(forward_value) && $stable(wide_mode))

	// every accepted beat yields a result beat in the next cycle
	`FMST_ASSERT_NEXT(a_one_result, clk, arst_n, in_valid && !in_stall, out_valid)

	// a beat with nothing forwarded carries a zero forward payload
	`FMST_ASSERT_NOW(a_fwd_idle, clk, arst_n, out_valid && !forward_valid, forward_register == '0 && forward_value == '0)

	// timer registers are never forwarded, and a forwarding beat carries a zero read byte
	`FMST_ASSERT_NOW(a_fwd_timer, clk, arst_n, out_valid && forward_valid, forward_register != REG_TIMER1 && forward_register != REG_TIMER2 && forward_register != REG_TIMER_CTRL && read_data == '0)

	// status byte shape: summary bit follows the two timer bits
	`FMST_ASSERT_NOW(a_status, clk, arst_n, out_valid && read_data != READ_BANK_HI, read_data[4:0] == '0 && read_data[7] == (read_data[6] || read_data[5]))

endmodule

bind fm_synth_timer_register_front fmst_checker u_fmst_checker (.*);

/* tb/fm_synth_timer_register_front_test.sv */
`timescale 1ns / 1ps

module fm_synth_timer_register_front_test;
	import fmst_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  port;
		logic [7:0]  data_byte;
		logic [15:0] elapsed_us;
	} bus_item_t;

	typedef struct packed {
		logic [7:0]       read_data;
		logic             forward_valid;
		logic [REG_W-1:0] forward_register;
		logic [7:0]       forward_value;
		logic             wide_mode;
	} front_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [TICK_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        kind = '0;
	logic [1:0]        port = '0;
	logic [7:0]        data_byte = '0;
	logic [15:0]       elapsed_us = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        read_data;
	logic              forward_valid;
	logic [REG_W-1:0]  forward_register;
	logic [7:0]        forward_value;
	logic              wide_mode;

	fm_synth_timer_register_front u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.port             (port),
		.data_byte        (data_byte),
		.elapsed_us       (elapsed_us),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.read_data        (read_data),
		.forward_valid    (forward_valid),
		.forward_register (forward_register),
		.forward_value    (forward_value),
		.wide_mode        (wide_mode)
	);

	// shadow of the front end state
	logic [TICK_W-1:0]  tick1 = TIMER1_TICK_RESET;
	logic [TICK_W-1:0]  tick2 = TIMER2_TICK_RESET;
	logic [REG_W-1:0]   latched_reg = '0;
	logic [CLOCK_W-1:0] now_us = '0;
	logic [7:0]         reload1 = '0;
	logic [7:0]         reload2 = '0;
	logic               run1 = 1'b0;
	logic               run2 = 1'b0;
	logic [CLOCK_W-1:0] due1 = '0;
	logic [CLOCK_W-1:0] due2 = '0;
	logic               opl3_mode = 1'b0;

	bus_item_t     pending_items[$];
	front_result_t expected_results[$];
	bus_item_t     offered;
	front_result_t want;
	int unsigned   send_gap = 0;
	bit            sender_calm = 1'b0;
	int unsigned   stall_left = 0;
	int unsigned   hold_left = 0;
	bit            hold_done = 1'b0;
	bit            sink_calm = 1'b0;
	int unsigned   results_seen = 0;
	int unsigned   fail_count = 0;
	int unsigned   cycle_count = 0;

	function automatic logic [CLOCK_W-1:0] clock_sum(logic [CLOCK_W-1:0] a,
		logic [CLOCK_W-1:0] b);
		logic [CLOCK_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CLOCK_W] ? '1 : s[CLOCK_W-1:0];
	endfunction

	function automatic logic [CLOCK_W-1:0] rearm(logic [7:0] reload, logic [TICK_W-1:0] tick);
		logic [CLOCK_W-1:0] span;
		span = CLOCK_W'(10'd256 - 10'(reload)) * CLOCK_W'(tick);
		return clock_sum(now_us, span);
	endfunction

	function automatic logic [7:0] timer_status();
		logic [7:0] s;
		s = '0;
		if (run1 && now_us > due1)
			s[6] = 1'b1;
		if (run2 && now_us > due2)
			s[5] = 1'b1;
		s[7] = s[6] | s[5];
		return s;
	endfunction

	function automatic front_result_t apply_bus_item(bus_item_t it);
		front_result_t res;
		res = '0;
		case (it.kind)
			KIND_WRITE: begin
				case (it.port)
					PORT_ADDR: latched_reg = {1'b0, it.data_byte};
					PORT_ADDR_HI: latched_reg = {1'b1, it.data_byte};
					PORT_DATA: begin
						case (latched_reg)
							REG_TIMER1: begin
								reload1 = it.data_byte;
								if (run1)
									due1 = rearm(reload1, tick1);
							end
							REG_TIMER2: begin
								reload2 = it.data_byte;
								if (run2)
									due2 = rearm(reload2, tick2);
							end
							REG_TIMER_CTRL: begin
								if (it.data_byte[7]) begin
									run1 = 1'b0;
									run2 = 1'b0;
								end else begin
									if (!it.data_byte[6]) begin
										run1 = it.data_byte[0];
										if (run1)
											due1 = rearm(reload1, tick1);
									end
									if (!it.data_byte[5]) begin
										run2 = it.data_byte[1];
										if (run2)
											due2 = rearm(reload2, tick2);
									end
								end
							end
							default: begin
								if (latched_reg == REG_NEW)
									opl3_mode = it.data_byte[0];
								res.forward_valid = 1'b1;
								res.forward_register = latched_reg;
								res.forward_value = it.data_byte;
							end
						endcase
					end
					default: ;
				endcase
			end
			KIND_READ: res.read_data = (it.port == PORT_ADDR_HI) ? READ_BANK_HI : timer_status();
			KIND_TIME: now_us = clock_sum(now_us, CLOCK_W'(it.elapsed_us));
			default: ;
		endcase
		res.wide_mode = opl3_mode;
		return res;
	endfunction

	function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s expected 0x%0h got 0x%0h", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	function automatic int unsigned idle_span(bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void push_item(logic [1:0] k, logic [1:0] p, logic [7:0] d,
		logic [15:0] e);
		bus_item_t it;
		it.kind = k;
		it.port = p;
		it.data_byte = d;
		it.elapsed_us = e;
		pending_items.push_back(it);
	endfunction

	function automatic void push_write(logic [1:0] addr_port, logic [7:0] addr, logic [7:0] d);
		push_item(KIND_WRITE, addr_port, addr, 16'($urandom));
		push_item(KIND_WRITE, PORT_DATA, d, 16'($urandom));
	endfunction

	// mostly address/data pairs with random content, some reads, ticks and noise
	function automatic void queue_random_traffic(int unsigned count);
		int unsigned target;
		int unsigned r;
		logic [7:0]  val;
		logic [15:0] span;
		target = pending_items.size() + count;
		while (pending_items.size() < target) begin
			r = $urandom_range(0, 99);
			val = 8'($urandom);
			if (r < 28) begin
				if ($urandom_range(0, 1) == 0)
					val = 8'($urandom_range(8'hF0, 8'hFF));
				push_write(PORT_ADDR, $urandom_range(0, 1) ? REG_TIMER1[7:0] : REG_TIMER2[7:0],
					val);
			end else if (r < 42) begin
				if ($urandom_range(0, 99) < 70)
					val[7] = 1'b0;
				push_write(PORT_ADDR, REG_TIMER_CTRL[7:0], val);
			end else if (r < 58) begin
				if ($urandom_range(0, 99) < 15)
					push_write(PORT_ADDR_HI, REG_NEW[7:0], val);
				else
					push_write($urandom_range(0, 1) ? PORT_ADDR_HI : PORT_ADDR, 8'($urandom), val);
			end else if (r < 74) begin
				push_item(KIND_READ, ($urandom_range(0, 99) < 70) ? PORT_ADDR : 2'($urandom), val,
					16'($urandom));
			end else if (r < 92) begin
				r = $urandom_range(0, 99);
				if (r < 35)
					span = 16'($urandom_range(0, 255));
				else if (r < 75)
					span = 16'($urandom_range(0, 8191));
				else
					span = 16'($urandom);
				push_item(KIND_TIME, 2'($urandom), val, span);
			end else begin
				push_item(2'($urandom), 2'($urandom), val, 16'($urandom));
			end
		end
	endfunction

	task automatic set_ticks(logic [TICK_W-1:0] t1, logic [TICK_W-1:0] t2);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TIMER1_TICK;
		cfg_data <= t1;
		@(posedge clk);
		cfg_index <= CFG_TIMER2_TICK;
		cfg_data <= t2;
		@(posedge clk);
		cfg_we <= 1'b0;
		tick1 = t1;
		tick2 = t2;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(apply_bus_item(offered));
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					offered = pending_items.pop_front();
					kind <= offered.kind;
					port <= offered.port;
					data_byte <= offered.data_byte;
					elapsed_us <= offered.elapsed_us;
					in_valid <= 1'b1;
					if ($urandom_range(0, 63) == 0)
						sender_calm = !sender_calm;
					send_gap = idle_span(sender_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with one long hold-off to back the block up
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && results_seen >= 300) begin
			hold_done = 1'b1;
			hold_left = 200;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 127) == 0)
				sink_calm = !sink_calm;
			stall_left = idle_span(sink_calm);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result beat with no expected result pending");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("read_data", 16'(want.read_data), 16'(read_data));
				check_field("forward_valid", 16'(want.forward_valid), 16'(forward_valid));
				check_field("forward_register", 16'(want.forward_register), 16'(forward_register));
				check_field("forward_value", 16'(want.forward_value), 16'(forward_value));
				check_field("wide_mode", 16'(want.wide_mode), 16'(wide_mode));
			end
			results_seen <= results_seen + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_ticks(TIMER1_TICK_RESET, TIMER2_TICK_RESET);

		push_write(PORT_ADDR, REG_TIMER1[7:0], 8'h00);
		push_write(PORT_ADDR, REG_TIMER2[7:0], 8'hFF);
		push_write(PORT_ADDR, REG_TIMER_CTRL[7:0], 8'h03);
		push_item(KIND_READ, PORT_ADDR, 8'h00, 16'h0000);
		push_item(KIND_TIME, PORT_ADDR, 8'hFF, 16'hFFFF);
		push_item(KIND_READ, PORT_ADDR, 8'hFF, 16'hFFFF);
		push_item(KIND_READ, PORT_ADDR_HI, 8'h00, 16'h0000);
		push_item(KIND_READ, 2'b11, 8'h00, 16'h0000);
		push_write(PORT_ADDR, REG_TIMER_CTRL[7:0], 8'h80);
		push_item(KIND_READ, PORT_DATA, 8'h00, 16'h0000);
		// mask timer 1, stop timer 2
		push_write(PORT_ADDR, REG_TIMER_CTRL[7:0], 8'h41);
		push_write(PORT_ADDR_HI, REG_NEW[7:0], 8'h01);
		push_write(PORT_ADDR_HI, 8'hFF, 8'hAA);
		push_write(PORT_ADDR, REG_NEW[7:0], 8'h00);
		push_write(PORT_ADDR_HI, REG_NEW[7:0], 8'hFE);
		push_item(KIND_WRITE, 2'b11, 8'hFF, 16'hFFFF);
		push_item(2'b11, 2'b11, 8'hFF, 16'hFFFF);
		push_item(KIND_TIME, PORT_DATA, 8'h00, 16'h0000);
		push_write(PORT_ADDR_HI, REG_TIMER1[7:0], 8'h55);
		queue_random_traffic(150);

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			case (ph)
				0: set_ticks(16'd1, 16'd1);
				1: set_ticks(16'hFFFF, 16'hFFFF);
				2: set_ticks(16'd0, 16'hFFFF);
				3: set_ticks(16'd80, 16'd0);
				4: set_ticks(16'($urandom), 16'($urandom));
				default: set_ticks(16'hFFFF, 16'd1);
			endcase
			queue_random_traffic(150);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
